// ----- rtl/utac_pkg.sv -----
// ----------------------------------------------------------------------------
// utac_pkg
// Shared types, constants and the one's-complement adder used by the UDP
// trailer appender and its output stage.
// ----------------------------------------------------------------------------
package utac_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MATCH_PORT    = 1'b0,
        REG_TRAILER_VALUE = 1'b1
    } t_cfg_reg;

    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] MATCH_PORT_RESET    = 16'd5050;
    localparam logic [7:0]  TRAILER_VALUE_RESET = 8'hFF;

    // Packet limits.
    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam logic [15:0] LAST_COUNT       = 16'hFFFF;

    // IPv4 header decoding.
    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [3:0]  MIN_IHL          = 4'd5;
    localparam logic [7:0]  UDP_PROTO        = 8'd17;
    localparam logic [5:0]  MIN_HEADER_BYTES = 6'd20;
    localparam logic [15:0] PROTO_OFFSET     = 16'd9;
    localparam logic [15:0] IP_TLEN_OFFSET   = 16'd2;
    localparam logic [15:0] IP_CSUM_OFFSET   = 16'd10;
    localparam logic [15:0] PSEUDO_START     = 16'd12;
    localparam logic [15:0] PSEUDO_END       = 16'd20;

    // Offsets within the UDP header.
    localparam logic [15:0] UDP_DPORT_HI     = 16'd2;
    localparam logic [15:0] UDP_DPORT_LO     = 16'd3;
    localparam logic [15:0] UDP_LEN_OFFSET   = 16'd4;
    localparam logic [15:0] UDP_CSUM_OFFSET  = 16'd6;
    localparam logic [15:0] UDP_HEADER_BYTES = 16'd8;

    // A UDP checksum of zero goes out as all ones.
    localparam logic [15:0] CSUM_ZERO_SUB    = 16'hFFFF;

    // One result item.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_trailer;
        logic        out_last;
        logic        matched;
        logic [15:0] new_total_length;
        logic [15:0] new_ip_checksum;
        logic [15:0] new_udp_length;
        logic [15:0] new_udp_checksum;
    } t_result;

    // 16-bit one's-complement addition with end-around carry.
    function automatic logic [15:0] add1c(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ----- rtl/utac_obuf.sv -----
// ----------------------------------------------------------------------------
// utac_obuf
// Output register of the trailer appender. Holds one result until the
// receiver takes it and reports when it can be loaded again.
// ----------------------------------------------------------------------------
module utac_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  utac_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_is_trailer,
    output logic              o_out_last,
    output logic              o_matched,
    output logic [15:0]       o_new_total_length,
    output logic [15:0]       o_new_ip_checksum,
    output logic [15:0]       o_new_udp_length,
    output logic [15:0]       o_new_udp_checksum
);
    import utac_pkg::*;

    logic    r_valid;
    t_result r_data;

    // The register can be loaded when empty or when its transaction completes.
    assign o_free = !r_valid || i_out_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out_valid        = r_valid;
    assign o_out_byte         = r_data.out_byte;
    assign o_is_trailer       = r_data.is_trailer;
    assign o_out_last         = r_data.out_last;
    assign o_matched          = r_data.matched;
    assign o_new_total_length = r_data.new_total_length;
    assign o_new_ip_checksum  = r_data.new_ip_checksum;
    assign o_new_udp_length   = r_data.new_udp_length;
    assign o_new_udp_checksum = r_data.new_udp_checksum;

endmodule

// ----- rtl/udp_trailer_append_checksum.sv -----
// ----------------------------------------------------------------------------
// udp_trailer_append_checksum
// Passes an IPv4 packet through byte by byte and appends a trailer to UDP
// packets bound for the configured port, with the patched header values.
// ----------------------------------------------------------------------------
// Usage:
//   Input bytes arrive on i_in_valid / o_in_ready with i_end_of_packet on the
//   final byte. Each accepted byte is loaded into an output register and is
//   presented in the next cycle on o_out_valid / i_out_ready.
//   When a packet is IPv4 UDP to the match port, TRAILER_BYTES trailer bytes
//   follow its last byte; the final result carries matched and the new total
//   length, IP checksum, UDP length and UDP checksum for a later patch stage.
//   Throughput is one byte per cycle while the output register is free and
//   no trailer is being added. After a matching packet the input is held off
//   while S_TRAIL folds the trailer into the UDP sum, S_FIN1 pads an odd
//   byte, S_FIN2 and S_FIN3 finish both sums and S_LAST loads the result.
//   Configuration writes on i_cfg_valid / o_cfg_ready are always accepted and
//   must only be issued while no packet is in flight.
//   Reset (synchronous, i_rst_n low) empties the output register, clears the
//   packet state and restores match port 5050 and trailer value 0xFF.
//   A stalled receiver holds the output register; the input is then taken
//   only in the cycle that the held result leaves.
// ----------------------------------------------------------------------------
module udp_trailer_append_checksum #(
    parameter int unsigned TRAILER_BYTES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [utac_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [utac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input byte channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_end_of_packet,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_is_trailer,
    output logic                               o_out_last,
    output logic                               o_matched,
    output logic [15:0]                        o_new_total_length,
    output logic [15:0]                        o_new_ip_checksum,
    output logic [15:0]                        o_new_udp_length,
    output logic [15:0]                        o_new_udp_checksum
);
    import utac_pkg::*;

    localparam int unsigned TW = (TRAILER_BYTES > 1) ? $clog2(TRAILER_BYTES) : 1;
    localparam logic [TW-1:0] LAST_IDX =
        TW'((TRAILER_BYTES > 0) ? TRAILER_BYTES - 1 : 0);
    localparam logic [15:0] TRAILER_LEN = 16'(TRAILER_BYTES);
    localparam logic [15:0] LEN_LIMIT   = 16'(MAX_PACKET_BYTES - TRAILER_BYTES);

    typedef enum logic [2:0] {
        S_BYTES,
        S_TRAIL,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_LAST
    } t_state;

    // Registers and their next values.
    t_state      r_state,      n_state;
    logic [15:0] r_match_port, n_match_port;
    logic [7:0]  r_tv,         n_tv;
    logic [15:0] r_count,      n_count;
    logic [5:0]  r_hb,         n_hb;
    logic [15:0] r_hdr_sum,    n_hdr_sum;
    logic [15:0] r_udp_sum,    n_udp_sum;
    logic [7:0]  r_held,       n_held;
    logic [15:0] r_port,       n_port;
    logic        r_udp4,       n_udp4;
    logic        r_ovf,        n_ovf;
    logic        r_pend,       n_pend;
    logic [TW-1:0] r_idx,      n_idx;
    logic [15:0] r_tl,         n_tl;
    logic [15:0] r_ul,         n_ul;
    logic [7:0]  r_last_byte,  n_last_byte;

    logic        out_free;
    logic        load;
    t_result     res;
    logic        in_take;
    logic [15:0] hb16;
    logic [15:0] pe;
    logic [15:0] word;
    logic        match;
    logic [15:0] uc_raw;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_BYTES) && out_free;
    assign in_take     = i_in_valid && o_in_ready;
    assign hb16        = {10'd0, r_hb};
    assign pe          = {r_count[15:1], 1'b0};
    assign word        = {r_held, i_data_byte};
    assign uc_raw      = ~r_udp_sum;

    // Next-state logic: byte parsing, trailer folding and checksum finish.
    always_comb begin
        n_state      = r_state;
        n_match_port = r_match_port;
        n_tv         = r_tv;
        n_count      = r_count;
        n_hb         = r_hb;
        n_hdr_sum    = r_hdr_sum;
        n_udp_sum    = r_udp_sum;
        n_held       = r_held;
        n_port       = r_port;
        n_udp4       = r_udp4;
        n_ovf        = r_ovf;
        n_pend       = r_pend;
        n_idx        = r_idx;
        n_tl         = r_tl;
        n_ul         = r_ul;
        n_last_byte  = r_last_byte;
        load         = 1'b0;
        res          = '0;
        match        = 1'b0;

        // Register writes.
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MATCH_PORT:    n_match_port = i_cfg_data[15:0];
                REG_TRAILER_VALUE: n_tv         = i_cfg_data[7:0];
                default:           n_match_port = r_match_port;
            endcase
        end

        unique case (r_state)
            S_BYTES: begin
                if (in_take) begin
                    // Fold the byte into the packet state.
                    if (r_count == LAST_COUNT) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + 16'd1;
                        if (r_count == 16'd0) begin
                            n_hb   = {i_data_byte[3:0], 2'b00};
                            n_udp4 = (i_data_byte[7:4] == IP_VERSION) &&
                                     (i_data_byte[3:0] >= MIN_IHL);
                        end
                        if (r_count == PROTO_OFFSET && i_data_byte != UDP_PROTO) begin
                            n_udp4 = 1'b0;
                        end
                        if (r_hb >= MIN_HEADER_BYTES) begin
                            if (r_count == hb16 + UDP_DPORT_HI) begin
                                n_port[15:8] = i_data_byte;
                            end
                            if (r_count == hb16 + UDP_DPORT_LO) begin
                                n_port[7:0] = i_data_byte;
                            end
                        end
                        if (!r_count[0]) begin
                            n_held = i_data_byte;
                        end else if (pe < hb16) begin
                            if (pe != IP_TLEN_OFFSET && pe != IP_CSUM_OFFSET) begin
                                n_hdr_sum = add1c(r_hdr_sum, word);
                            end
                            if (pe >= PSEUDO_START && pe < PSEUDO_END) begin
                                n_udp_sum = add1c(r_udp_sum, word);
                            end
                        end else if (pe != hb16 + UDP_LEN_OFFSET &&
                                     pe != hb16 + UDP_CSUM_OFFSET) begin
                            n_udp_sum = add1c(r_udp_sum, word);
                        end
                    end

                    res.out_byte = i_data_byte;

                    if (i_end_of_packet) begin
                        // Match decision on the state that includes this byte.
                        match = n_udp4 && !n_ovf && (n_hb >= MIN_HEADER_BYTES) &&
                                (n_count >= {10'd0, n_hb} + UDP_HEADER_BYTES) &&
                                (n_port == r_match_port) && (n_count <= LEN_LIMIT);
                        n_pend      = n_count[0];
                        n_idx       = '0;
                        n_last_byte = i_data_byte;
                        if (!match) begin
                            load         = 1'b1;
                            res.out_last = 1'b1;
                            n_count      = '0;
                            n_hb         = '0;
                            n_hdr_sum    = '0;
                            n_udp_sum    = '0;
                            n_held       = '0;
                            n_port       = '0;
                            n_udp4       = 1'b0;
                            n_ovf        = 1'b0;
                        end else if (TRAILER_BYTES == 0) begin
                            n_state = S_FIN1;
                        end else begin
                            load    = 1'b1;
                            n_state = S_TRAIL;
                        end
                    end else begin
                        load = 1'b1;
                    end
                end
            end

            S_TRAIL: begin
                // A trailer byte a cycle unless stalled; all but last go out.
                if (r_idx == LAST_IDX || out_free) begin
                    load           = (r_idx != LAST_IDX);
                    res.out_byte   = r_tv;
                    res.is_trailer = 1'b1;
                    if (r_pend) begin
                        n_udp_sum = add1c(r_udp_sum, {r_held, r_tv});
                        n_pend    = 1'b0;
                    end else begin
                        n_held = r_tv;
                        n_pend = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN1;
                    end else begin
                        n_idx = r_idx + TW'(1);
                    end
                end
            end

            S_FIN1: begin
                // Odd final byte pads to a word; lengths from the byte count.
                if (r_pend) begin
                    n_udp_sum = add1c(r_udp_sum, {r_held, 8'd0});
                end
                n_tl    = r_count + TRAILER_LEN;
                n_ul    = r_count + TRAILER_LEN - hb16;
                n_state = S_FIN2;
            end

            S_FIN2: begin
                // Header gets the new length; UDP length counted twice (rotate).
                n_hdr_sum = add1c(r_hdr_sum, r_tl);
                n_udp_sum = add1c(r_udp_sum, {r_ul[14:0], r_ul[15]});
                n_state   = S_FIN3;
            end

            S_FIN3: begin
                // Protocol word of the pseudo-header.
                n_udp_sum = add1c(r_udp_sum, {8'd0, UDP_PROTO});
                n_state   = S_LAST;
            end

            S_LAST: begin
                // Final result with the header values, then a fresh packet.
                if (out_free) begin
                    load                 = 1'b1;
                    res.out_byte         = (TRAILER_BYTES == 0) ? r_last_byte : r_tv;
                    res.is_trailer       = (TRAILER_BYTES != 0);
                    res.out_last         = 1'b1;
                    res.matched          = 1'b1;
                    res.new_total_length = r_tl;
                    res.new_ip_checksum  = ~r_hdr_sum;
                    res.new_udp_length   = r_ul;
                    res.new_udp_checksum = (uc_raw == 16'd0) ? CSUM_ZERO_SUB : uc_raw;
                    n_count              = '0;
                    n_hb                 = '0;
                    n_hdr_sum            = '0;
                    n_udp_sum            = '0;
                    n_held               = '0;
                    n_port               = '0;
                    n_udp4               = 1'b0;
                    n_ovf                = 1'b0;
                    n_state              = S_BYTES;
                end
            end

            default: n_state = S_BYTES;
        endcase
    end

    // State and registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_BYTES;
            r_match_port <= MATCH_PORT_RESET;
            r_tv         <= TRAILER_VALUE_RESET;
            r_count      <= '0;
            r_hb         <= '0;
            r_hdr_sum    <= '0;
            r_udp_sum    <= '0;
            r_held       <= '0;
            r_port       <= '0;
            r_udp4       <= 1'b0;
            r_ovf        <= 1'b0;
            r_pend       <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_match_port <= n_match_port;
            r_tv         <= n_tv;
            r_count      <= n_count;
            r_hb         <= n_hb;
            r_hdr_sum    <= n_hdr_sum;
            r_udp_sum    <= n_udp_sum;
            r_held       <= n_held;
            r_port       <= n_port;
            r_udp4       <= n_udp4;
            r_ovf        <= n_ovf;
            r_pend       <= n_pend;
            r_idx        <= n_idx;
        end
        r_tl        <= n_tl;
        r_ul        <= n_ul;
        r_last_byte <= n_last_byte;
    end

    // Output register.
    utac_obuf u_obuf (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (load),
        .i_result           (res),
        .o_free             (out_free),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_is_trailer       (o_is_trailer),
        .o_out_last         (o_out_last),
        .o_matched          (o_matched),
        .o_new_total_length (o_new_total_length),
        .o_new_ip_checksum  (o_new_ip_checksum),
        .o_new_udp_length   (o_new_udp_length),
        .o_new_udp_checksum (o_new_udp_checksum)
    );

    // A rewritten packet never reports a zero UDP checksum.
    a_udp_csum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_matched) |-> (o_new_udp_checksum != 16'd0))
        else $error("matched result carries a zero UDP checksum");

    // The IP total length always exceeds the UDP length by the IP header.
    a_len_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_matched) |-> (o_new_total_length > o_new_udp_length))
        else $error("new total length not above new UDP length");

    // Descriptor fields only travel on the final result of a packet.
    a_desc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_last) |-> (!o_matched && o_new_total_length == 16'd0))
        else $error("descriptor fields on a non-final result");

    // No input byte is taken while a trailer or checksum finish is under way.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_BYTES) |-> !in_take)
        else $error("input accepted during trailer sequence");

endmodule
